FILE: hw/rtl/rems_pkg.sv
`default_nettype none
package rems_pkg;

    localparam int MAX_COLUMNS = 8192;
    localparam int SAMPLE_ROWS = 9;

    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int WID_W   = COL_W + 1;
    localparam int ROW_W   = $clog2(SAMPLE_ROWS + 1);
    localparam int ADDR_W  = $clog2(SAMPLE_ROWS);
    localparam int ENTRY_W = 2 * COL_W;

    localparam logic [ROW_W-1:0] LAST_ROW    = ROW_W'(SAMPLE_ROWS - 1);
    localparam logic [ADDR_W-1:0] LAST_IDX   = ADDR_W'(SAMPLE_ROWS - 1);
    localparam logic [ROW_W-1:0] MEDIAN_RANK = ROW_W'(SAMPLE_ROWS / 2);

    localparam logic [WID_W-1:0] WIDTH_MIN   = WID_W'(2);
    localparam logic [WID_W-1:0] WIDTH_MAX   = WID_W'(MAX_COLUMNS);
    localparam logic [WID_W-1:0] WIDTH_RESET = WID_W'(8192);
    localparam logic [7:0]       THRESH_RESET = 8'd220;

    // register index, taken from paddr[2]
    localparam logic REG_THRESH = 1'b0;
    localparam logic REG_WIDTH  = 1'b1;

    typedef enum logic [2:0] {
        ST_SCAN,
        ST_RD_I,
        ST_LD_I,
        ST_RD_J,
        ST_CMP_J,
        ST_OUT
    } rems_state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rems_ram.sv
`default_nettype none
module rems_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 9
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/row_edge_scan_median.sv
// row_edge_scan_median: paper-edge finder over nine sampled image rows.
//
// Input channel (s_valid/s_ready/s_pixel): one beat per pixel, rows sent
// back to back, left to right. The block counts columns against the
// row_width register (saturated to 2..8192) and takes a pixel every cycle
// while it scans.
// After the last pixel of the ninth row the block ranks the stored rows by
// width (right edge minus left edge, widest first, ties to the earlier row)
// with one shared subtract/compare unit: for each candidate row it reads and
// loads that row, then reads and compares every stored row in turn, as each
// edge store read is registered. The ST_OUT step then loads the output register.
// s_ready is low throughout, longer if an earlier result waits on m_ready.
// Output channel (m_valid/m_ready/m_left_edge/m_right_edge): one beat per
// nine rows, held in a register until taken; scanning of the next rows
// goes on while it waits.
// APB port: register 0 at 0x0 is dark_threshold, register 1 at 0x4 is
// row_width. Write them only while idle.
// Reset (aresetn low, synchronous) clears the column and row counters and
// the output valid, and restores threshold 220 and width 8192.
`default_nettype none
module row_edge_scan_median
    import rems_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_pixel,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [12:0]      m_left_edge,
    output logic [12:0]      m_right_edge,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    rems_state_t state_reg, state_next;

    logic [7:0]       thresh_reg;
    logic [WID_W-1:0] width_reg;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] left_reg;
    logic [COL_W-1:0] right_reg;
    logic             found_reg;
    logic [ROW_W-1:0] row_cnt_reg;

    logic [ADDR_W-1:0] i_reg;
    logic [ADDR_W-1:0] j_reg;
    logic [ROW_W-1:0]  rank_reg;
    logic signed [WID_W-1:0] wi_reg;
    logic [COL_W-1:0]  li_reg;
    logic [COL_W-1:0]  ri_reg;
    logic [COL_W-1:0]  pick_l_reg;
    logic [COL_W-1:0]  pick_r_reg;

    logic             m_valid_reg;
    logic [COL_W-1:0] m_left_reg;
    logic [COL_W-1:0] m_right_reg;

    // APB
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
            width_reg  <= WIDTH_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_THRESH: thresh_reg <= pwdata[7:0];
                REG_WIDTH:  width_reg  <= pwdata[WID_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_THRESH: prdata = {24'd0, thresh_reg};
            REG_WIDTH:  prdata = {{(32 - WID_W){1'b0}}, width_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // pixel scan datapath
    logic [WID_W-1:0] w_use;
    logic [COL_W-1:0] half;
    logic             dark;
    logic             row_last;
    logic             px_take;
    logic [COL_W-1:0] left_next;
    logic [COL_W-1:0] right_next;
    logic             found_next;

    always_comb begin
        if (width_reg < WIDTH_MIN) begin
            w_use = WIDTH_MIN;
        end else if (width_reg > WIDTH_MAX) begin
            w_use = WIDTH_MAX;
        end else begin
            w_use = width_reg;
        end
    end

    assign half     = w_use[WID_W-1:1];
    assign dark     = s_pixel < thresh_reg;
    assign row_last = ({1'b0, col_reg} + WID_W'(1)) >= w_use;
    assign px_take  = s_valid & s_ready;

    always_comb begin
        left_next  = left_reg;
        found_next = found_reg;
        right_next = right_reg;
        if (dark && (col_reg < half) && !found_reg) begin
            left_next  = col_reg;
            found_next = 1'b1;
        end
        if (dark && (col_reg > half)) begin
            right_next = col_reg;
        end
    end

    // edge store
    logic              ram_we;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    assign ram_we = px_take & row_last;

    rems_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SAMPLE_ROWS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (row_cnt_reg[ADDR_W-1:0]),
        .wr_data ({left_next, right_next}),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // shared width compare unit
    logic [COL_W-1:0]        lj;
    logic [COL_W-1:0]        rj;
    logic signed [WID_W-1:0] wj;
    logic                    beats;
    logic [ROW_W-1:0]        rank_next;

    assign lj        = ram_rdata[ENTRY_W-1:COL_W];
    assign rj        = ram_rdata[COL_W-1:0];
    assign wj        = $signed({1'b0, rj}) - $signed({1'b0, lj});
    assign beats     = (wj > wi_reg) || ((wj == wi_reg) && (j_reg < i_reg));
    assign rank_next = rank_reg + ROW_W'(beats);

    // control
    logic load_out;
    logic sel_done;

    assign sel_done = (state_reg == ST_CMP_J) && (j_reg == LAST_IDX) && (i_reg == LAST_IDX);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_SCAN: begin
                if (px_take && row_last && (row_cnt_reg == LAST_ROW)) begin
                    state_next = ST_RD_I;
                end
            end
            ST_RD_I:  state_next = ST_LD_I;
            ST_LD_I:  state_next = ST_RD_J;
            ST_RD_J:  state_next = ST_CMP_J;
            ST_CMP_J: begin
                if (j_reg != LAST_IDX) begin
                    state_next = ST_RD_J;
                end else if (i_reg != LAST_IDX) begin
                    state_next = ST_RD_I;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_SCAN;
                end
            end
            default: state_next = ST_SCAN;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        ram_raddr = i_reg;
        load_out  = 1'b0;
        case (state_reg)
            ST_SCAN:  s_ready = 1'b1;
            ST_RD_I:  ram_raddr = i_reg;
            ST_RD_J:  ram_raddr = j_reg;
            ST_OUT:   load_out = !m_valid_reg || m_ready;
            default:  ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SCAN;
        end else begin
            state_reg <= state_next;
        end
    end

    // row scan registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            left_reg    <= '0;
            right_reg   <= '0;
            found_reg   <= 1'b0;
            row_cnt_reg <= '0;
        end else if (px_take) begin
            if (!row_last) begin
                col_reg   <= col_reg + COL_W'(1);
                left_reg  <= left_next;
                right_reg <= right_next;
                found_reg <= found_next;
            end else begin
                col_reg   <= '0;
                left_reg  <= '0;
                right_reg <= '0;
                found_reg <= 1'b0;
                if (row_cnt_reg == LAST_ROW) begin
                    row_cnt_reg <= '0;
                end else begin
                    row_cnt_reg <= row_cnt_reg + ROW_W'(1);
                end
            end
        end
    end

    // median selection sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg    <= '0;
            j_reg    <= '0;
            rank_reg <= '0;
        end else begin
            case (state_reg)
                ST_SCAN: i_reg <= '0;
                ST_LD_I: begin
                    j_reg    <= '0;
                    rank_reg <= '0;
                end
                ST_CMP_J: begin
                    rank_reg <= rank_next;
                    if (j_reg != LAST_IDX) begin
                        j_reg <= j_reg + ADDR_W'(1);
                    end else if (i_reg != LAST_IDX) begin
                        i_reg <= i_reg + ADDR_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LD_I) begin
            li_reg <= lj;
            ri_reg <= rj;
            wi_reg <= wj;
        end
        // the row whose rank lands on the median is the pick
        if ((state_reg == ST_CMP_J) && (j_reg == LAST_IDX) && (rank_next == MEDIAN_RANK)) begin
            pick_l_reg <= li_reg;
            pick_r_reg <= ri_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_left_reg  <= pick_l_reg;
            m_right_reg <= pick_r_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_left_edge  = m_left_reg;
    assign m_right_edge = m_right_reg;

    // checks
    a_out_from_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result beat raised outside the output step");

    a_rows_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_SCAN) |-> (row_cnt_reg == '0) && (col_reg == '0))
        else $error("row counters not cleared during selection");

    a_cmp_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP_J) |-> $past(state_reg) == ST_RD_J)
        else $error("compare without a store read");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_SCAN) |-> (i_reg <= LAST_IDX) && (j_reg <= LAST_IDX))
        else $error("selection index out of range");

    a_out_after_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_done |=> state_reg == ST_OUT)
        else $error("selection end did not reach output step");

endmodule
`default_nettype wire
